/* rtl/sitda_pkg.sv */
package sitda_pkg;

  // Field and internal types.
  typedef logic signed [63:0] value_t;
  typedef logic [63:0]        mag_t;
  typedef logic [7:0]         char_t;
  typedef logic [4:0]         pow_idx_t;
  typedef logic [3:0]         digit_t;
  typedef logic [1:0]         bit_idx_t;

  // Decimal positions of a 64-bit magnitude no larger than 2^63.
  localparam int unsigned PowCount = 19;
  localparam pow_idx_t    PowTop   = pow_idx_t'(PowCount - 1);

  localparam char_t DigitBase = 8'd48;
  localparam char_t MinusCode = 8'd45;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic emit_sign;
    logic emit_digit;
    logic next_pow;
  } sitda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_neg;
    logic bit_zero;
    logic digit_zero;
    logic started;
    logic pow_last;
    logic slot_free;
  } sitda_stat_t;

  // Powers of ten, 10^0 through 10^18.
  function automatic mag_t pow10(input pow_idx_t k);
    mag_t p;
    p = '0;
    case (k)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

/* rtl/sitda_in_if.sv */
interface sitda_in_if;
  import sitda_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* rtl/sitda_out_if.sv */
interface sitda_out_if;
  import sitda_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;
  logic  last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

/* rtl/signed_integer_to_decimal_ascii.sv */
// Converts one signed 64-bit integer per input beat into its decimal ASCII
// text, one character per output beat, most significant first, with a leading
// '-' for negative values and last set on the final digit; the most negative
// value converts correctly. Digits come from restoring trial subtraction of
// 8, 4, 2 and 1 times each power of ten, one 64-bit subtract per cycle, so
// every one of the 19 decimal positions takes four trials plus one emit or
// skip step; an emit waits while the output register is held. A new value is
// taken only once the previous value's last digit has entered the output
// register.
module signed_integer_to_decimal_ascii (
  input logic         clk,
  input logic         rst_n,
  sitda_in_if.sink    in_ch,
  sitda_out_if.source out_ch
);
  import sitda_pkg::*;

  sitda_cmd_t  cmd;
  sitda_stat_t stat;

  // Sequencer.
  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Magnitude, digit extraction and output register.
  sitda_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_ch.value),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_char_code (out_ch.char_code),
    .out_last      (out_ch.last),
    .cmd           (cmd),
    .stat          (stat)
  );

  // A value is converted alone: no second beat is taken right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while a conversion is running");

  // Every character is a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.char_code == MinusCode) ||
                     ((out_ch.char_code >= DigitBase) &&
                      (out_ch.char_code <= DigitBase + 8'd9)))
    else $error("character outside the sign and digit codes");

  // The sign is always followed by a digit.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.char_code == MinusCode) |-> !out_ch.last)
    else $error("sign character marked as last");

endmodule

/* rtl/sitda_ctrl.sv */
module sitda_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sitda_pkg::sitda_stat_t stat,
  output sitda_pkg::sitda_cmd_t  cmd
);
  import sitda_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SIGN,
    S_STEP,
    S_DIGIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequencing: sign for negative values, then four trial subtractions and an emit or skip per decimal position.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_neg ? S_SIGN : S_STEP;
        end
      end
      S_SIGN: begin
        if (stat.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (stat.bit_zero) begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (stat.digit_zero && !stat.started && !stat.pow_last) begin
          // Leading zero: skip this position without a beat.
          cmd.next_pow = 1'b1;
          state_nxt    = S_STEP;
        end else if (stat.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.pow_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next_pow = 1'b1;
            state_nxt    = S_STEP;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/sitda_dp.sv */
module sitda_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sitda_pkg::value_t      in_value,
  input  logic                   out_ready,
  output logic                   out_valid,
  output sitda_pkg::char_t       out_char_code,
  output logic                   out_last,
  input  sitda_pkg::sitda_cmd_t  cmd,
  output sitda_pkg::sitda_stat_t stat
);
  import sitda_pkg::*;

  mag_t     mag_r,      mag_nxt;
  pow_idx_t pow_idx_r,  pow_idx_nxt;
  bit_idx_t bit_r,      bit_nxt;
  digit_t   digit_r,    digit_nxt;
  logic     started_r,  started_nxt;
  logic     out_valid_r, out_valid_nxt;
  char_t    out_char_r, out_char_nxt;
  logic     out_last_r, out_last_nxt;

  mag_t        weight;
  logic [64:0] trial;
  logic        slot_free;

  // Trial subtraction of (2^bit) * 10^k from the remaining magnitude.
  assign weight    = pow10(pow_idx_r) << bit_r;
  assign trial     = {1'b0, mag_r} - {1'b0, weight};
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    stat.in_neg     = in_value[63];
    stat.bit_zero   = (bit_r == '0);
    stat.digit_zero = (digit_r == '0);
    stat.started    = started_r;
    stat.pow_last   = (pow_idx_r == '0);
    stat.slot_free  = slot_free;
  end

  // Next-value logic for the magnitude, digit and output register.
  always_comb begin
    mag_nxt       = mag_r;
    pow_idx_nxt   = pow_idx_r;
    bit_nxt       = bit_r;
    digit_nxt     = digit_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (cmd.load) begin
      mag_nxt     = in_value[63] ? (~mag_t'(in_value) + 64'd1) : mag_t'(in_value);
      pow_idx_nxt = PowTop;
      bit_nxt     = 2'd3;
      digit_nxt   = '0;
      started_nxt = 1'b0;
    end

    if (cmd.step) begin
      if (!trial[64]) begin
        mag_nxt          = trial[63:0];
        digit_nxt[bit_r] = 1'b1;
      end
      if (bit_r != '0) begin
        bit_nxt = bit_r - 2'd1;
      end
    end

    if (cmd.emit_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = MinusCode;
      out_last_nxt  = 1'b0;
    end

    if (cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = DigitBase + char_t'(digit_r);
      out_last_nxt  = (pow_idx_r == '0);
      started_nxt   = 1'b1;
    end

    if (cmd.next_pow) begin
      pow_idx_nxt = pow_idx_r - 5'd1;
      bit_nxt     = 2'd3;
      digit_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    pow_idx_r  <= pow_idx_nxt;
    bit_r      <= bit_nxt;
    digit_r    <= digit_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule
